// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Check that post holds in the cycle after pre.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared result codes and the queue entry type of the stream deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpsd_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KindConsumed = 3'd0,
    KindHeader   = 3'd1,
    KindPayload  = 3'd2,
    KindEnd      = 3'd3,
    KindBadMark  = 3'd4,
    KindIgnored  = 3'd5
  } kind_e;

  // Byte-order marks and the end-of-stream length
  localparam logic [31:0] MarkBig    = 32'h0102_0304;
  localparam logic [31:0] MarkLittle = 32'h0403_0201;
  localparam logic [31:0] EndLength  = 32'hFFFF_FFFF;

  // One classified result, as it travels from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last_in_packet;
    logic [31:0] packet_length;
  } lpsd_item_t;

endpackage

`default_nettype wire

// File: rtl/core/lpsd_front.sv
// ----------------------------------------------------------------------------
// lpsd_front
// Parser front end: accepts stream bytes, tracks mark/header/payload phases
// and pushes one classified result per byte into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpsd_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [7:0]                stream_byte_i,
  input  wire                       full_i,
  output logic                      push_o,
  output lpsd_pkg::lpsd_item_t      item_o
);
  import lpsd_pkg::*;

  localparam logic [2:0] PhMark    = 3'd0;
  localparam logic [2:0] PhHeader  = 3'd1;
  localparam logic [2:0] PhPayload = 3'd2;
  localparam logic [2:0] PhEnded   = 3'd3;
  localparam logic [2:0] PhBadMark = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic [23:0] word_q, word_d;
  logic        big_q, big_d;
  logic [31:0] remain_q, remain_d;

  logic        accept;
  logic [31:0] full_word;
  logic [31:0] length;
  logic [31:0] remain_dec;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept;

  // Assemble the word with the incoming byte as the least significant one
  assign full_word  = {word_q, stream_byte_i};
  assign length     = big_q ? full_word
                            : {stream_byte_i, word_q[7:0], word_q[15:8], word_q[23:16]};
  assign remain_dec = (remain_q != 32'd0) ? (remain_q - 32'd1) : remain_q;

  // Classify the byte and compute the next parser state
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    word_d   = word_q;
    big_d    = big_q;
    remain_d = remain_q;
    item_o   = '{kind: KindConsumed, payload_byte: 8'd0,
                 last_in_packet: 1'b0, packet_length: 32'd0};

    unique case (phase_q)
      PhMark: begin
        if (pos_q == 2'd3) begin
          pos_d  = 2'd0;
          word_d = 24'd0;
          if (full_word == MarkBig) begin
            big_d   = 1'b1;
            phase_d = PhHeader;
          end else if (full_word == MarkLittle) begin
            big_d   = 1'b0;
            phase_d = PhHeader;
          end else begin
            phase_d     = PhBadMark;
            item_o.kind = KindBadMark;
          end
        end else begin
          pos_d  = pos_q + 2'd1;
          word_d = full_word[23:0];
        end
      end
      PhHeader: begin
        if (pos_q == 2'd3) begin
          pos_d  = 2'd0;
          word_d = 24'd0;
          if (length == 32'd0) begin
            item_o.kind = KindConsumed;
          end else if (length == EndLength) begin
            phase_d     = PhEnded;
            item_o.kind = KindEnd;
          end else begin
            remain_d             = length;
            phase_d              = PhPayload;
            item_o.kind          = KindHeader;
            item_o.packet_length = length;
          end
        end else begin
          pos_d  = pos_q + 2'd1;
          word_d = full_word[23:0];
        end
      end
      PhPayload: begin
        item_o.kind         = KindPayload;
        item_o.payload_byte = stream_byte_i;
        remain_d            = remain_dec;
        if (remain_dec == 32'd0) begin
          item_o.last_in_packet = 1'b1;
          phase_d               = PhHeader;
          pos_d                 = 2'd0;
          word_d                = 24'd0;
        end
      end
      PhBadMark: begin
        item_o.kind = KindBadMark;
      end
      default: begin
        item_o.kind = KindIgnored;
      end
    endcase
  end

  // Advance parser state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMark;
      pos_q    <= 2'd0;
      word_q   <= 24'd0;
      big_q    <= 1'b0;
      remain_q <= 32'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      word_q   <= word_d;
      big_q    <= big_d;
      remain_q <= remain_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lpsd_fifo.sv
// ----------------------------------------------------------------------------
// lpsd_fifo
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpsd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  lpsd_pkg::lpsd_item_t      push_item_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire                       pop_i,
  output lpsd_pkg::lpsd_item_t      pop_item_o
);
  import lpsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  lpsd_item_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lpsd_back.sv
// ----------------------------------------------------------------------------
// lpsd_back
// Output stage: drains the queue into a registered result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpsd_back (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       q_valid_i,
  input  lpsd_pkg::lpsd_item_t      q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output lpsd_pkg::lpsd_item_t      out_item_o
);
  import lpsd_pkg::*;

  logic       valid_q;
  lpsd_item_t item_q;
  logic       load;

  // Refill when empty or when the current transaction leaves
  assign load        = q_valid_i & (~valid_q | out_ready_i);
  assign q_pop_o     = load;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= q_item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/length_prefixed_stream_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_stream_deframer
// Byte-order-marked, length-prefixed stream deframer, one result per byte.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock and answers every byte with one
// result transaction, in order. The first four bytes are a byte-order mark
// (04 03 02 01 little-endian lengths, 01 02 03 04 big-endian); anything else
// reports a sticky bad mark. Then 4-byte length headers follow: zero is
// skipped, all ones ends the stream, any other value announces that many
// payload bytes, the last of which is flagged. A byte is accepted every
// cycle while the result queue has room; the parser state is registered per
// accepted byte, and each result passes through the queue and then the
// output register on its way to the output.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_stream_deframer #(
  parameter int unsigned FifoDepth = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_in_packet_o,
  output logic [31:0] packet_length_o
);
  import lpsd_pkg::*;

  logic       push;
  logic       full;
  lpsd_item_t push_item;
  logic       q_valid;
  logic       q_pop;
  lpsd_item_t q_item;
  lpsd_item_t out_item;

  // Parse and classify
  lpsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Decouple front and back
  lpsd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (q_item)
  );

  // Present results
  lpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item)
  );

  assign kind_o           = out_item.kind;
  assign payload_byte_o   = out_item.payload_byte;
  assign last_in_packet_o = out_item.last_in_packet;
  assign packet_length_o  = out_item.packet_length;

  // Field consistency of delivered results and queueing of accepted bytes
  `ASSERT_IMPLIES(a_payload_zero, clk_i, rst_ni, out_valid_o && (kind_o != KindPayload), payload_byte_o == 8'd0)
  `ASSERT_IMPLIES(a_length_zero, clk_i, rst_ni, out_valid_o && (kind_o != KindHeader), packet_length_o == 32'd0)
  `ASSERT_IMPLIES(a_last_payload, clk_i, rst_ni, out_valid_o && last_in_packet_o, kind_o == KindPayload)
  `ASSERT_NEXT(a_accept_queued, clk_i, rst_ni, in_valid_i && in_ready_o, q_valid)

endmodule

`default_nettype wire

// File: tb/deframer_check.sv
// ----------------------------------------------------------------------------
// deframer_check
// Watches both channels of the stream deframer. Predicts one result per
// accepted byte and compares every returned result, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deframer_check (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [7:0]  stream_byte_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [2:0]  kind_i,
  input  wire  [7:0]  payload_byte_i,
  input  wire         last_in_packet_i,
  input  wire  [31:0] packet_length_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import lpsd_pkg::*;

  typedef enum logic [2:0] {
    ParseMark,
    ParseHeader,
    ParsePayload,
    ParseEnded,
    ParseBadMark
  } parse_state_e;

  // Parser state as the block should hold it
  parse_state_e parse_state;
  logic [1:0]   word_pos;
  logic [31:0]  word_acc;
  logic         lengths_big;
  logic [31:0]  bytes_left;

  lpsd_item_t   pending_results[$];
  lpsd_item_t   oldest;
  int           fail_count;
  int           checked;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_results.size();
  assign checked_o    = checked;

  // Advance the parser by one byte and return the result it answers with
  function automatic lpsd_item_t deframe_byte(input logic [7:0] b);
    lpsd_item_t  r;
    logic [31:0] word;
    logic [31:0] len;
    logic        full;
    r.kind           = KindConsumed;
    r.payload_byte   = '0;
    r.last_in_packet = 1'b0;
    r.packet_length  = '0;
    word = {word_acc[23:0], b};
    full = (word_pos == 2'd3);
    case (parse_state)
      ParseMark: begin
        word_acc = word;
        word_pos = word_pos + 2'd1;
        if (full) begin
          if (word == MarkBig) begin
            lengths_big = 1'b1;
            parse_state = ParseHeader;
          end else if (word == MarkLittle) begin
            lengths_big = 1'b0;
            parse_state = ParseHeader;
          end else begin
            parse_state = ParseBadMark;
            r.kind      = KindBadMark;
          end
          word_acc = '0;
        end
      end
      ParseHeader: begin
        word_acc = word;
        word_pos = word_pos + 2'd1;
        if (full) begin
          len = lengths_big ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
          word_acc = '0;
          if (len == EndLength) begin
            parse_state = ParseEnded;
            r.kind      = KindEnd;
          end else if (len != '0) begin
            bytes_left      = len;
            parse_state     = ParsePayload;
            r.kind          = KindHeader;
            r.packet_length = len;
          end
        end
      end
      ParsePayload: begin
        r.kind         = KindPayload;
        r.payload_byte = b;
        if (bytes_left != '0) bytes_left = bytes_left - 32'd1;
        if (bytes_left == '0) begin
          r.last_in_packet = 1'b1;
          parse_state      = ParseHeader;
          word_pos         = '0;
          word_acc         = '0;
        end
      end
      ParseBadMark: r.kind = KindBadMark;
      default:      r.kind = KindIgnored;
    endcase
    return r;
  endfunction

  // Compare returned results first, then queue the prediction for a new byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_state = ParseMark;
      word_pos    = '0;
      word_acc    = '0;
      lengths_big = 1'b0;
      bytes_left  = '0;
      pending_results.delete();
      fail_count  = 0;
      checked     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result: kind %0d byte %02h last %0b len %08h",
                     $realtime, kind_i, payload_byte_i, last_in_packet_i, packet_length_i);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (kind_i !== oldest.kind || payload_byte_i !== oldest.payload_byte ||
              last_in_packet_i !== oldest.last_in_packet ||
              packet_length_i !== oldest.packet_length) begin
            if (fail_count < 10)
              $display({"[%0t] result %0d mismatch: expected kind %0d byte %02h last %0b ",
                        "len %08h, got kind %0d byte %02h last %0b len %08h"},
                       $realtime, checked, oldest.kind, oldest.payload_byte,
                       oldest.last_in_packet, oldest.packet_length, kind_i,
                       payload_byte_i, last_in_packet_i, packet_length_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(deframe_byte(stream_byte_i));
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream deframer test: drives a framed byte stream with a random byte-order
// mark, length headers and payload, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lpsd_pkg::*;

  localparam int StreamBytes = 1350;
  localparam int QuietAfter  = 1150;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte    = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_in_packet;
  logic [31:0] packet_length;

  int fail_count;
  int pending;
  int checked;
  int bytes_sent = 0;
  int packets    = 0;
  int empty_hdrs = 0;
  bit allow_idle = 1'b1;
  bit lengths_big;

  length_prefixed_stream_deframer u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .stream_byte_i    (stream_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .payload_byte_o   (payload_byte),
    .last_in_packet_o (last_in_packet),
    .packet_length_o  (packet_length)
  );

  deframer_check u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .stream_byte_i    (stream_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .payload_byte_i   (payload_byte),
    .last_in_packet_i (last_in_packet),
    .packet_length_i  (packet_length),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall in random bursts, none in the quiet tail
  initial begin
    @(posedge clk);
    forever begin
      if (allow_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offer one byte, hold it until the transaction, then maybe idle
  task automatic send_byte(input logic [7:0] b);
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= QuietAfter) allow_idle = 1'b0;
    if (allow_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Send a 32-bit word in the byte order the mark declared
  task automatic send_header(input logic [31:0] len);
    if (lengths_big) begin
      for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    end else begin
      for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
    end
    if (len == '0) empty_hdrs++;
    else if (len != EndLength) packets++;
  endtask

  // Hold off the sender until every result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random byte, biased toward the extremes
  function automatic logic [7:0] rand_stream_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [31:0] mark;
    logic [31:0] len;
    int          mark_sel;
    int          pick;
    bit          bad_mark;
    bit          end_tail;
    bit          drained_mid;
    drained_mid = 1'b0;
    bad_mark    = 1'b0;
    end_tail    = 1'b0;
    mark_sel    = $urandom_range(0, 9);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pick the byte-order mark for this run: mostly valid, sometimes corrupt
    lengths_big = (mark_sel <= 5);
    if (mark_sel == 0) begin
      bad_mark = 1'b1;
      if ($urandom_range(0, 1) == 0) begin
        mark = ($urandom_range(0, 1) ? MarkBig : MarkLittle) ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        mark = $urandom();
        if (mark == MarkBig || mark == MarkLittle) mark = ~mark;
      end
    end else begin
      mark = lengths_big ? MarkBig : MarkLittle;
    end
    for (int i = 3; i >= 0; i--) send_byte(mark[8*i +: 8]);

    if (bad_mark) begin
      // Every later byte must keep reporting the bad mark
      send_byte(8'h00);
      send_byte(8'hFF);
      hold_until_drained();
      while (bytes_sent < StreamBytes) send_byte(rand_stream_byte());
    end else begin
      // Directed: empty header, one-byte packet, short packet
      send_header(32'd0);
      send_header(32'd1);
      send_byte(8'hFF);
      send_header(32'd3);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      hold_until_drained();

      // Random packets, mostly short, a few spanning the second length byte
      while (bytes_sent < StreamBytes) begin
        if (!drained_mid && bytes_sent >= StreamBytes / 2) begin
          hold_until_drained();
          drained_mid = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          len = 32'd0;
        end else if (pick < 70) begin
          len = $urandom_range(1, 16);
        end else if (pick < 92) begin
          len = $urandom_range(17, 64);
        end else begin
          len = $urandom_range(65, 600);
        end
        // Keep the stream close to its planned size
        if (len > 32'(StreamBytes - bytes_sent)) len = 32'(StreamBytes - bytes_sent);
        send_header(len);
        repeat (len) send_byte(rand_stream_byte());
      end

      // Close with the end marker or open a packet too long to finish
      end_tail = ($urandom_range(0, 1) == 0);
      if (end_tail) begin
        send_header(EndLength);
        repeat (20) send_byte(rand_stream_byte());
      end else begin
        case ($urandom_range(0, 2))
          0:       len = 32'hFFFF_FFFE;
          1:       len = 32'h8000_0000 | $urandom();
          default: len = 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
        endcase
        if (len == EndLength) len = 32'hFFFF_FFFE;
        send_header(len);
        repeat (40) send_byte(rand_stream_byte());
      end
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d stream bytes behind a %s byte-order mark; %0d results checked.",
             bytes_sent, bad_mark ? "corrupt" : (lengths_big ? "big-endian" : "little-endian"),
             checked);
    $display("%0d packets, %0d empty headers, stream closed by %s.", packets, empty_hdrs,
             bad_mark ? "the mark error" : (end_tail ? "the end marker" : "an unfinished packet"));
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: length_prefixed_stream_deframer.f
+incdir+rtl/core
rtl/core/lpsd_pkg.sv
rtl/core/lpsd_front.sv
rtl/core/lpsd_fifo.sv
rtl/core/lpsd_back.sv
rtl/core/length_prefixed_stream_deframer.sv
tb/deframer_check.sv
tb/testbench.sv
